[sv/pca_pkg.sv]
`default_nettype none
package pca_pkg;

  localparam int unsigned PriorityLevels = 3;
  localparam int unsigned QueueDepth     = 8;
  localparam int unsigned LeaseSlots     = 16;
  localparam int unsigned ByteWidth      = 40;
  localparam int unsigned CfgWidth       = 40;
  localparam int unsigned ReqTypeWidth   = 3;
  localparam int unsigned PrioWidth      = 2;
  localparam int unsigned TicketWidth    = 5;
  localparam int unsigned LeaseIdWidth   = 4;
  localparam int unsigned StatusWidth    = 3;

  localparam logic [ReqTypeWidth-1:0] ReqQueued  = 3'd0;
  localparam logic [ReqTypeWidth-1:0] ReqBest    = 3'd1;
  localparam logic [ReqTypeWidth-1:0] ReqCancel  = 3'd2;
  localparam logic [ReqTypeWidth-1:0] ReqReserve = 3'd3;
  localparam logic [ReqTypeWidth-1:0] ReqRelease = 3'd4;
  localparam logic [ReqTypeWidth-1:0] ReqClose   = 3'd5;

  localparam logic [StatusWidth-1:0] StOk      = 3'd0;
  localparam logic [StatusWidth-1:0] StQueued  = 3'd1;
  localparam logic [StatusWidth-1:0] StInvalid = 3'd2;
  localparam logic [StatusWidth-1:0] StAggr    = 3'd3;
  localparam logic [StatusWidth-1:0] StPerOp   = 3'd4;
  localparam logic [StatusWidth-1:0] StDenied  = 3'd5;
  localparam logic [StatusWidth-1:0] StNoSlot  = 3'd6;

  localparam logic CfgAggregate = 1'b0;
  localparam logic CfgPerOp     = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, decide status
    logic scan;     // advance skipped heads
    logic grant;    // grant selected head, release the held result
    logic emit_st;  // release the held result as the final one
  } pca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pump_req;  // request wants the pump afterward
    logic skip;      // some head is canceled and must be popped
    logic can_grant; // a head fits and a slot is free
  } pca_stat_t;

endpackage
`default_nettype wire

[sv/priority_credit_admission.sv]
// Byte-credit admission controller with three strict-priority queues and a lease table.
// A request is taken when start is high and busy is low. A request without a pump keeps
// busy high only through the evaluation state; its status result is held from load and
// then registered out with strobe_o, and a new request is taken once busy is low again.
// A request that runs the pump (queued admission, cancel, release, close) then pops
// each canceled head, grants each head that fits, stops, and ends in a closing state.
// Each result is held until the next pump step shows whether another follows: it goes
// out the cycle after the next grant, or in the closing cycle as the final one. Results
// last one cycle each and the receiver cannot stall them; last_o marks the final one.
`default_nettype none
module priority_credit_admission #(
  parameter int unsigned ByteWidth      = pca_pkg::ByteWidth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [ByteWidth-1:0]              cfg_data_i,
  input  wire logic [pca_pkg::ReqTypeWidth-1:0]  req_type_i,
  input  wire logic [pca_pkg::PrioWidth-1:0]     priority_req_i,
  input  wire logic [ByteWidth-1:0]              peak_bytes_i,
  input  wire logic [ByteWidth-1:0]              baseline_bytes_i,
  input  wire logic [ByteWidth-1:0]              byte_count_i,
  input  wire logic [pca_pkg::LeaseIdWidth-1:0]  lease_id_i,
  input  wire logic [pca_pkg::TicketWidth-1:0]   ticket_id_i,
  output logic                                   strobe_o,
  output logic                                   kind_o,
  output logic [pca_pkg::StatusWidth-1:0]        status_o,
  output logic [pca_pkg::TicketWidth-1:0]        out_ticket_o,
  output logic [pca_pkg::LeaseIdWidth-1:0]       out_lease_o,
  output logic [ByteWidth-1:0]                   reserved_total_o,
  output logic                                   last_o
);

  pca_pkg::pca_cmd_t  cmd;
  pca_pkg::pca_stat_t stat;
  logic ctrl_last, last_q;

  pca_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .cmd_o(cmd),
    .busy_o(busy), .last_o(ctrl_last)
  );

  pca_dp #(
    .ByteWidth(ByteWidth)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i, .priority_req_i, .peak_bytes_i, .baseline_bytes_i,
    .byte_count_i, .lease_id_i, .ticket_id_i,
    .res_valid_o(strobe_o), .kind_o, .status_o, .out_ticket_o, .out_lease_o,
    .reserved_total_o
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) last_q <= 1'b0;
    else         last_q <= ctrl_last;
  end

  assign last_o = strobe_o && last_q;

  property p_load_busy;
    @(posedge clk_i) disable iff (!rst_ni) cmd.load |=> busy;
  endproperty
  a_load_busy: assert property (p_load_busy) else $error("busy not raised after load");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.scan, cmd.grant, cmd.emit_st}))
    else $error("controller issued two commands");

  a_no_start_twice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !cmd.load) else $error("second load back to back");

endmodule
`default_nettype wire

[sv/pca_ctrl.sv]
`default_nettype none
module pca_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire pca_pkg::pca_stat_t stat_i,
  output pca_pkg::pca_cmd_t       cmd_o,
  output logic                    busy_o,
  output logic                    last_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_PUMP = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    last_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.pump_req) begin
          state_d = S_PUMP;
        end else begin
          cmd_o.emit_st = 1'b1;
          last_o        = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_PUMP: begin
        // one head per cycle: pop canceled, else grant, else stop
        if (stat_i.skip) begin
          cmd_o.scan = 1'b1;
        end else if (stat_i.can_grant) begin
          cmd_o.grant = 1'b1;
        end else begin
          // nothing follows, so the held result is the final one
          cmd_o.emit_st = 1'b1;
          last_o        = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[sv/pca_dp.sv]
`default_nettype none
module pca_dp #(
  parameter int unsigned ByteWidth      = pca_pkg::ByteWidth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pca_pkg::pca_cmd_t                 cmd_i,
  output pca_pkg::pca_stat_t                     stat_o,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [ByteWidth-1:0]              cfg_data_i,
  input  wire logic [pca_pkg::ReqTypeWidth-1:0]  req_type_i,
  input  wire logic [pca_pkg::PrioWidth-1:0]     priority_req_i,
  input  wire logic [ByteWidth-1:0]              peak_bytes_i,
  input  wire logic [ByteWidth-1:0]              baseline_bytes_i,
  input  wire logic [ByteWidth-1:0]              byte_count_i,
  input  wire logic [pca_pkg::LeaseIdWidth-1:0]  lease_id_i,
  input  wire logic [pca_pkg::TicketWidth-1:0]   ticket_id_i,
  output logic                                   res_valid_o,
  output logic                                   kind_o,
  output logic [pca_pkg::StatusWidth-1:0]        status_o,
  output logic [pca_pkg::TicketWidth-1:0]        out_ticket_o,
  output logic [pca_pkg::LeaseIdWidth-1:0]       out_lease_o,
  output logic [ByteWidth-1:0]                   reserved_total_o
);

  localparam int unsigned PriorityLevels = pca_pkg::PriorityLevels;
  localparam int unsigned QueueDepth     = pca_pkg::QueueDepth;
  localparam int unsigned LeaseSlots     = pca_pkg::LeaseSlots;
  localparam int unsigned Tickets = PriorityLevels * QueueDepth;
  localparam int unsigned QW      = $clog2(QueueDepth);
  localparam int unsigned CW      = $clog2(QueueDepth + 1);
  localparam int unsigned TW      = pca_pkg::TicketWidth;
  localparam int unsigned LW      = pca_pkg::LeaseIdWidth;
  localparam int unsigned PW      = (PriorityLevels > 1) ? $clog2(PriorityLevels) : 1;
  localparam int unsigned SW      = (LeaseSlots > 1) ? $clog2(LeaseSlots) : 1;

  logic [ByteWidth-1:0] aggr_q, perop_q;
  logic [ByteWidth-1:0] qpeak_q [Tickets];
  logic [ByteWidth-1:0] qbase_q [Tickets];
  logic [Tickets-1:0]   pend_q;
  logic [QW-1:0]        head_q  [PriorityLevels];
  logic [CW-1:0]        count_q [PriorityLevels];
  logic [LeaseSlots-1:0] lvalid_q;
  logic [ByteWidth-1:0] lres_q  [LeaseSlots];
  logic [ByteWidth-1:0] lbase_q [LeaseSlots];
  logic [ByteWidth-1:0] total_q;

  // held result: the status after load, then each grant in turn
  logic [pca_pkg::StatusWidth-1:0] st_q, st_d;
  logic [TW-1:0]        tk_q, tk_d;
  logic [LW-1:0]        ls_q, ls_d;
  logic                 hk_q;
  logic                 pumpreq_q, pumpreq_d;
  logic                 rv_q, kind_q;
  logic [pca_pkg::StatusWidth-1:0] ost_q;
  logic [TW-1:0]        otk_q;
  logic [LW-1:0]        ols_q;
  logic [ByteWidth-1:0] rtot_q;

  // shared helpers
  logic [ByteWidth-1:0] eff;
  logic [ByteWidth-1:0] credit;
  assign eff    = (perop_q < aggr_q) ? perop_q : aggr_q;
  assign credit = (total_q > aggr_q) ? '0 : aggr_q - total_q;

  // first free slot
  logic          slot_found;
  logic [SW-1:0] slot_idx;
  always_comb begin
    slot_found = 1'b0;
    slot_idx   = '0;
    for (int i = LeaseSlots - 1; i >= 0; i--) begin
      if (!lvalid_q[i]) begin
        slot_found = 1'b1;
        slot_idx   = SW'(i);
      end
    end
  end

  // head selection for the pump
  logic          hsel_found, hsel_skip;
  logic [PW-1:0] hsel_p;
  logic [TW-1:0] hsel_t;
  always_comb begin
    hsel_found = 1'b0;
    hsel_skip  = 1'b0;
    hsel_p     = '0;
    for (int p = PriorityLevels - 1; p >= 0; p--) begin
      if (count_q[p] != '0) begin
        hsel_found = 1'b1;
        hsel_p     = PW'(p);
        hsel_skip  = !pend_q[p * QueueDepth + int'(head_q[p])];
      end
    end
    hsel_t = TW'(int'(hsel_p) * QueueDepth + int'(head_q[hsel_p]));
  end

  logic [ByteWidth-1:0] hpeak;
  assign hpeak = qpeak_q[hsel_t];

  assign stat_o.pump_req  = pumpreq_q;
  assign stat_o.skip      = hsel_found && hsel_skip;
  assign stat_o.can_grant = hsel_found && !hsel_skip && (hpeak <= credit) && slot_found;

  // request decode
  logic [ByteWidth:0]   pb_sum;
  logic [ByteWidth-1:0] lim_rem;
  logic                 prio_ok, lease_ok, any_pend_upto, any_pend;
  logic [QW-1:0]        tail;
  logic [TW-1:0]        new_t;
  logic [LW-1:0]        lid;
  logic [ByteWidth:0]   lb_lr;
  always_comb begin
    lid      = lease_id_i;
    pb_sum   = {1'b0, peak_bytes_i} + {1'b0, baseline_bytes_i};
    prio_ok  = int'(priority_req_i) < PriorityLevels;
    lease_ok = int'(lid) < LeaseSlots && lvalid_q[SW'(lid)];
    any_pend = |pend_q;
    any_pend_upto = 1'b0;
    for (int t = 0; t < Tickets; t++) begin
      if (pend_q[t] && (t / QueueDepth) <= int'(priority_req_i)) any_pend_upto = 1'b1;
    end
    tail  = QW'((int'(head_q[PW'(priority_req_i)]) + int'(count_q[PW'(priority_req_i)]))
                % QueueDepth);
    new_t = TW'(int'(priority_req_i) * QueueDepth + int'(tail));
    lb_lr = {1'b0, lbase_q[SW'(lid)]} + {1'b0, lres_q[SW'(lid)]};
    lim_rem = eff - lb_lr[ByteWidth-1:0];
  end

  logic [pca_pkg::StatusWidth-1:0] chk;
  always_comb begin
    if (!prio_ok || pb_sum[ByteWidth]) chk = pca_pkg::StInvalid;
    else if (peak_bytes_i > aggr_q) chk = pca_pkg::StAggr;
    else if (pb_sum[ByteWidth-1:0] > eff) chk = pca_pkg::StPerOp;
    else chk = pca_pkg::StOk;
  end

  // decision made at load, also computes state changes
  logic do_enq, do_best, do_cancel, do_res, do_rel, do_close;
  always_comb begin
    st_d = pca_pkg::StInvalid; tk_d = '0; ls_d = '0; pumpreq_d = 1'b0;
    do_enq = 1'b0; do_best = 1'b0; do_cancel = 1'b0;
    do_res = 1'b0; do_rel = 1'b0; do_close = 1'b0;
    case (req_type_i)
      pca_pkg::ReqQueued: begin
        if (chk != pca_pkg::StOk) st_d = chk;
        else if (int'(count_q[PW'(priority_req_i)]) >= QueueDepth) st_d = pca_pkg::StNoSlot;
        else begin
          st_d = pca_pkg::StQueued; tk_d = new_t; pumpreq_d = 1'b1; do_enq = 1'b1;
        end
      end
      pca_pkg::ReqBest: begin
        if (chk != pca_pkg::StOk) st_d = chk;
        else if (any_pend_upto || peak_bytes_i > credit) st_d = pca_pkg::StDenied;
        else if (!slot_found) st_d = pca_pkg::StNoSlot;
        else begin
          st_d = pca_pkg::StOk; ls_d = LW'(slot_idx); do_best = 1'b1;
        end
      end
      pca_pkg::ReqCancel: begin
        if (int'(ticket_id_i) >= Tickets) st_d = pca_pkg::StInvalid;
        else begin
          st_d = pca_pkg::StOk; pumpreq_d = 1'b1; do_cancel = 1'b1;
        end
      end
      pca_pkg::ReqReserve: begin
        if (byte_count_i == '0) st_d = pca_pkg::StOk;
        else if (!lease_ok) st_d = pca_pkg::StInvalid;
        else if (any_pend || lbase_q[SW'(lid)] > eff || lb_lr > {1'b0, eff}
                 || byte_count_i > lim_rem || byte_count_i > credit)
          st_d = pca_pkg::StDenied;
        else begin
          st_d = pca_pkg::StOk; do_res = 1'b1;
        end
      end
      pca_pkg::ReqRelease: begin
        if (!lease_ok || byte_count_i > lres_q[SW'(lid)]) st_d = pca_pkg::StInvalid;
        else if (byte_count_i == '0) st_d = pca_pkg::StOk;
        else begin
          st_d = pca_pkg::StOk; pumpreq_d = 1'b1; do_rel = 1'b1;
        end
      end
      pca_pkg::ReqClose: begin
        if (!lease_ok) st_d = pca_pkg::StInvalid;
        else begin
          st_d = pca_pkg::StOk; pumpreq_d = 1'b1; do_close = 1'b1;
        end
      end
      default: st_d = pca_pkg::StInvalid;
    endcase
  end

  // payload stores, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && do_enq) begin
      qpeak_q[new_t] <= peak_bytes_i;
      qbase_q[new_t] <= baseline_bytes_i;
    end
    if (cmd_i.load && do_best) begin
      lres_q[slot_idx]  <= peak_bytes_i;
      lbase_q[slot_idx] <= baseline_bytes_i;
    end
    if (cmd_i.load && do_res) lres_q[SW'(lid)] <= lres_q[SW'(lid)] + byte_count_i;
    if (cmd_i.load && do_rel) lres_q[SW'(lid)] <= lres_q[SW'(lid)] - byte_count_i;
    if (cmd_i.load && do_close) lres_q[SW'(lid)] <= '0;
    if (cmd_i.grant) begin
      lres_q[slot_idx]  <= hpeak;
      lbase_q[slot_idx] <= qbase_q[hsel_t];
    end
    if (cmd_i.load) begin
      st_q <= st_d; tk_q <= tk_d; ls_q <= ls_d; hk_q <= 1'b0;
    end else if (cmd_i.grant) begin
      st_q <= pca_pkg::StOk; tk_q <= hsel_t; ls_q <= LW'(slot_idx); hk_q <= 1'b1;
    end
    // a result goes out once the next pump step shows whether more follow
    otk_q  <= tk_q;
    ols_q  <= ls_q;
    ost_q  <= st_q;
    rtot_q <= total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aggr_q    <= '0;
      perop_q   <= '0;
      pend_q    <= '0;
      lvalid_q  <= '0;
      total_q   <= '0;
      pumpreq_q <= 1'b0;
      rv_q      <= 1'b0;
      kind_q    <= 1'b0;
      for (int p = 0; p < PriorityLevels; p++) begin
        head_q[p]  <= '0;
        count_q[p] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == pca_pkg::CfgAggregate) aggr_q <= cfg_data_i;
        else perop_q <= cfg_data_i;
      end
      rv_q   <= cmd_i.emit_st || cmd_i.grant;
      kind_q <= hk_q;
      if (cmd_i.load) begin
        pumpreq_q <= pumpreq_d;
        if (do_enq) begin
          pend_q[new_t] <= 1'b1;
          count_q[PW'(priority_req_i)] <= count_q[PW'(priority_req_i)] + 1'b1;
        end
        if (do_best) begin
          lvalid_q[slot_idx] <= 1'b1;
          total_q <= total_q + peak_bytes_i;
        end
        if (do_cancel) pend_q[ticket_id_i] <= 1'b0;
        if (do_res) total_q <= total_q + byte_count_i;
        if (do_rel) total_q <= total_q - byte_count_i;
        if (do_close) begin
          total_q <= total_q - lres_q[SW'(lid)];
          lvalid_q[SW'(lid)] <= 1'b0;
        end
      end
      if (cmd_i.scan || cmd_i.grant) begin
        head_q[hsel_p]  <= QW'((int'(head_q[hsel_p]) + 1) % QueueDepth);
        count_q[hsel_p] <= count_q[hsel_p] - 1'b1;
      end
      if (cmd_i.grant) begin
        pend_q[hsel_t]     <= 1'b0;
        lvalid_q[slot_idx] <= 1'b1;
        total_q            <= total_q + hpeak;
      end
    end
  end

  // the total shown is the one after this result
  assign res_valid_o      = rv_q;
  assign kind_o           = kind_q;
  assign status_o         = ost_q;
  assign out_ticket_o     = otk_q;
  assign out_lease_o      = ols_q;
  assign reserved_total_o = rtot_q;

endmodule
`default_nettype wire
